FILE: sv/fmg_pkg.sv
// Shared types and constants for the fall motion gate.
package fmg_pkg;

    // Configuration register indexes (byte address = 4 * index)
    typedef enum logic [1:0] {
        REG_MIN_MOTION = 2'd0,
        REG_FALL_TH    = 2'd1,
        REG_SCREAM_TH  = 2'd2
    } t_reg_idx;

    localparam logic [15:0] MIN_MOTION_RST = 16'd8192;
    localparam logic [15:0] FALL_TH_RST    = 16'd52429;
    localparam logic [15:0] SCREAM_TH_RST  = 16'd52429;

    // 1 g expressed as 100 * magnitude in 2^-16 m/s^2 units
    localparam logic [30:0] ONE_G_NUM   = 31'd64290816;
    localparam logic [31:0] DEV_HALF    = 32'd7848;
    // deviations at or above 15696 * 65536 saturate
    localparam logic [31:0] DEV_SAT_LIM = 32'd1028653056;
    localparam logic [9:0]  DIV_981     = 10'd981;
    localparam int          RECIP_SHIFT = 36;
    localparam logic [26:0] DIV_RECIP   = 27'((64'd1 << RECIP_SHIFT) / 64'd981);

    typedef struct packed {
        logic [15:0] min_motion_delta;
        logic [15:0] fall_threshold;
        logic [15:0] scream_threshold;
    } t_cfg;

    // Item handed from the front end to the engine
    typedef struct packed {
        logic [31:0] sum_sq;
        logic        window_end;
        logic [15:0] fall_score;
        logic [15:0] scream_score;
    } t_job;

    typedef struct packed {
        logic [15:0] fall_level;
        logic [15:0] scream_level;
        logic        fall_suppressed;
        logic        alert;
        logic [15:0] peak_delta;
    } t_result;

endpackage

FILE: sv/fmg_front.sv
// Front end: accepts samples and forms the sum of squared axes.
module fmg_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [15:0]  i_accel_x,
    input  logic signed [15:0]  i_accel_y,
    input  logic signed [15:0]  i_accel_z,
    input  logic                i_window_end,
    input  logic [15:0]         i_fall_score,
    input  logic [15:0]         i_scream_score,
    output fmg_pkg::t_job       o_job,
    output logic                o_job_valid,
    input  logic                i_job_ready
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_SQ,
        F_PUSH
    } t_fstate;

    t_fstate            r_state;
    logic [1:0]         r_axis;
    logic signed [15:0] r_x, r_y, r_z;
    logic [31:0]        r_acc;
    logic               r_wend;
    logic [15:0]        r_fall, r_scream;

    logic signed [15:0] axis_val;
    logic [15:0]        axis_mag;
    logic [31:0]        axis_sq;

    always_comb begin
        case (r_axis)
            2'd0:    axis_val = r_x;
            2'd1:    axis_val = r_y;
            default: axis_val = r_z;
        endcase
        // -32768 maps to 0x8000, which still fits unsigned
        axis_mag = axis_val[15] ? (~axis_val + 16'd1) : axis_val;
        axis_sq  = 32'(axis_mag) * 32'(axis_mag);
    end

    assign o_ready     = (r_state == F_IDLE);
    assign o_job_valid = (r_state == F_PUSH);
    assign o_job       = '{sum_sq: r_acc, window_end: r_wend,
                           fall_score: r_fall, scream_score: r_scream};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_axis  <= 2'd0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_valid) begin
                        r_x      <= i_accel_x;
                        r_y      <= i_accel_y;
                        r_z      <= i_accel_z;
                        r_wend   <= i_window_end;
                        r_fall   <= i_fall_score;
                        r_scream <= i_scream_score;
                        r_acc    <= '0;
                        r_axis   <= 2'd0;
                        r_state  <= F_SQ;
                    end
                end
                F_SQ: begin
                    r_acc <= r_acc + axis_sq;
                    if (r_axis == 2'd2) begin
                        r_state <= F_PUSH;
                    end else begin
                        r_axis <= r_axis + 2'd1;
                    end
                end
                F_PUSH: begin
                    if (i_job_ready) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

FILE: sv/fmg_fifo.sv
// Short job queue between the front end and the engine.
module fmg_fifo #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  fmg_pkg::t_job i_data,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    output fmg_pkg::t_job o_data,
    output logic          o_pop_valid,
    input  logic          i_pop_ready
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    fmg_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push, do_pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_data       = r_mem[r_rd_ptr];
    assign do_push      = i_push_valid && o_push_ready;
    assign do_pop       = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

FILE: sv/fmg_engine.sv
// Engine: square root, deviation from 1 g, window peak and decision.
module fmg_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fmg_pkg::t_job    i_job,
    input  logic             i_job_valid,
    output logic             o_job_ready,
    input  fmg_pkg::t_cfg    i_cfg,
    output fmg_pkg::t_result o_res,
    output logic             o_res_valid,
    input  logic             i_res_ready
);

    typedef enum logic [2:0] {
        E_IDLE,
        E_SQRT,
        E_SCALE,
        E_RECIP,
        E_CORR,
        E_FIN
    } t_estate;

    t_estate          r_state;
    fmg_pkg::t_job    r_job;
    logic [3:0]       r_cnt;
    logic [47:0]      r_rad;
    logic [24:0]      r_rem;
    logic [23:0]      r_root;
    logic [31:0]      r_np;
    logic [25:0]      r_a;
    logic [15:0]      r_q0;
    logic             r_sat;
    logic [15:0]      r_dev;
    logic [15:0]      r_peak;
    fmg_pkg::t_result r_res;
    logic             r_res_valid;

    // two root digits per cycle
    logic [47:0] rad_v;
    logic [24:0] rem_v;
    logic [23:0] root_v;
    logic [26:0] rem_t, trial;

    always_comb begin
        rad_v  = r_rad;
        rem_v  = r_rem;
        root_v = r_root;
        rem_t  = '0;
        trial  = '0;
        for (int k = 0; k < 2; k++) begin
            rem_t = {rem_v, rad_v[47:46]};
            trial = {1'b0, root_v, 2'b01};
            if (rem_t >= trial) begin
                rem_v  = 25'(rem_t - trial);
                root_v = {root_v[22:0], 1'b1};
            end else begin
                rem_v  = 25'(rem_t);
                root_v = {root_v[22:0], 1'b0};
            end
            rad_v = {rad_v[45:0], 2'b00};
        end
    end

    logic [30:0] m100, n_abs;
    logic [31:0] np;
    logic [52:0] prod;
    logic [25:0] q0x981, rem_q;
    logic [15:0] dev;

    always_comb begin
        m100   = 31'(r_root) * 31'(100);
        n_abs  = (m100 >= fmg_pkg::ONE_G_NUM) ? (m100 - fmg_pkg::ONE_G_NUM)
                                              : (fmg_pkg::ONE_G_NUM - m100);
        np     = 32'(n_abs) + fmg_pkg::DEV_HALF;
        // q0 is the true quotient or one short of it
        prod   = 53'(r_np[29:4]) * 53'(fmg_pkg::DIV_RECIP);
        q0x981 = 26'(r_q0) * 26'(fmg_pkg::DIV_981);
        rem_q  = r_a - q0x981;
        if (r_sat) begin
            dev = 16'hFFFF;
        end else if (rem_q >= 26'(fmg_pkg::DIV_981)) begin
            dev = r_q0 + 16'd1;
        end else begin
            dev = r_q0;
        end
    end

    logic [15:0] peak_new, fall_lvl;
    logic        supp, alert, res_load;

    always_comb begin
        peak_new = (r_dev > r_peak) ? r_dev : r_peak;
        supp     = (r_job.fall_score >= i_cfg.fall_threshold) &&
                   (peak_new < i_cfg.min_motion_delta);
        fall_lvl = supp ? 16'd0 : r_job.fall_score;
        alert    = (fall_lvl >= i_cfg.fall_threshold) ||
                   (r_job.scream_score >= i_cfg.scream_threshold);
        res_load = (r_state == E_FIN) && r_job.window_end &&
                   (!r_res_valid || i_res_ready);
    end

    assign o_job_ready = (r_state == E_IDLE);
    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= E_IDLE;
            r_peak      <= '0;
            r_res_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (res_load) begin
                r_res_valid <= 1'b1;
            end else if (r_res_valid && i_res_ready) begin
                r_res_valid <= 1'b0;
            end
            case (r_state)
                E_IDLE: begin
                    if (i_job_valid) begin
                        r_job   <= i_job;
                        r_rad   <= {i_job.sum_sq, 16'd0};
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_cnt   <= '0;
                        r_state <= E_SQRT;
                    end
                end
                E_SQRT: begin
                    r_rad  <= rad_v;
                    r_rem  <= rem_v;
                    r_root <= root_v;
                    if (r_cnt == 4'd11) begin
                        r_state <= E_SCALE;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                E_SCALE: begin
                    r_np    <= np;
                    r_state <= E_RECIP;
                end
                E_RECIP: begin
                    r_sat   <= (r_np >= fmg_pkg::DEV_SAT_LIM);
                    r_a     <= r_np[29:4];
                    r_q0    <= prod[fmg_pkg::RECIP_SHIFT +: 16];
                    r_state <= E_CORR;
                end
                E_CORR: begin
                    r_dev   <= dev;
                    r_state <= E_FIN;
                end
                E_FIN: begin
                    if (!r_job.window_end) begin
                        r_peak  <= peak_new;
                        r_state <= E_IDLE;
                    end else if (res_load) begin
                        r_res   <= '{fall_level: fall_lvl,
                                     scream_level: r_job.scream_score,
                                     fall_suppressed: supp,
                                     alert: alert,
                                     peak_delta: peak_new};
                        r_peak  <= '0;
                        r_state <= E_IDLE;
                    end
                end
                default: r_state <= E_IDLE;
            endcase
        end
    end

endmodule

FILE: sv/fall_motion_gate.sv
// Fall motion gate: top level with APB register file, front end, queue and engine.
// The engine takes one item at a time, through two-digit square root steps, then
// scale, reciprocal multiply, correction and decision, and so sets the throughput.
// The front end squares the three axes of one sample before it takes the next;
// the queue holds its jobs while the engine is busy.
// Synchronous active-low reset clears the peak, queue, control and registers.
module fall_motion_gate #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic               i_window_end,
    input  logic [15:0]        i_fall_score,
    input  logic [15:0]        i_scream_score,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_fall_level,
    output logic [15:0]        o_scream_level,
    output logic               o_fall_suppressed,
    output logic               o_alert,
    output logic [15:0]        o_peak_delta
);

    fmg_pkg::t_cfg    r_cfg;
    fmg_pkg::t_job    w_push_job, w_pop_job;
    logic             w_push_valid, w_push_ready;
    logic             w_pop_valid, w_pop_ready;
    fmg_pkg::t_result w_res;
    fmg_pkg::t_reg_idx reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = fmg_pkg::t_reg_idx'(paddr[3:2]);

    always_comb begin
        case (reg_idx)
            fmg_pkg::REG_MIN_MOTION: prdata = 32'(r_cfg.min_motion_delta);
            fmg_pkg::REG_FALL_TH:    prdata = 32'(r_cfg.fall_threshold);
            fmg_pkg::REG_SCREAM_TH:  prdata = 32'(r_cfg.scream_threshold);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{min_motion_delta: fmg_pkg::MIN_MOTION_RST,
                       fall_threshold: fmg_pkg::FALL_TH_RST,
                       scream_threshold: fmg_pkg::SCREAM_TH_RST};
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                fmg_pkg::REG_MIN_MOTION: r_cfg.min_motion_delta <= pwdata[15:0];
                fmg_pkg::REG_FALL_TH:    r_cfg.fall_threshold   <= pwdata[15:0];
                fmg_pkg::REG_SCREAM_TH:  r_cfg.scream_threshold <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    fmg_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_accel_x      (i_accel_x),
        .i_accel_y      (i_accel_y),
        .i_accel_z      (i_accel_z),
        .i_window_end   (i_window_end),
        .i_fall_score   (i_fall_score),
        .i_scream_score (i_scream_score),
        .o_job          (w_push_job),
        .o_job_valid    (w_push_valid),
        .i_job_ready    (w_push_ready)
    );

    fmg_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_data       (w_push_job),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .o_data       (w_pop_job),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready)
    );

    fmg_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_pop_job),
        .i_job_valid (w_pop_valid),
        .o_job_ready (w_pop_ready),
        .i_cfg       (r_cfg),
        .o_res       (w_res),
        .o_res_valid (o_valid),
        .i_res_ready (i_ready)
    );

    assign o_fall_level      = w_res.fall_level;
    assign o_scream_level    = w_res.scream_level;
    assign o_fall_suppressed = w_res.fall_suppressed;
    assign o_alert           = w_res.alert;
    assign o_peak_delta      = w_res.peak_delta;

    // the front end is busy squaring right after taking an item
    a_front_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("front end took a second item while squaring");

    // a job held back by a full queue is not dropped
    a_job_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push_valid && !w_push_ready) |=> (w_push_valid && $stable(w_push_job)))
        else $error("queued job lost while queue full");

    // a suppressed result always carries a zero fall level
    a_supp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fall_suppressed) |-> (o_fall_level == 16'd0))
        else $error("suppressed fall level not zero");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

FILE: tb/fmg_checker.sv
// Checker for the fall motion gate: mirrors the register file, predicts decisions, compares.
`timescale 1ns / 100ps

module fmg_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               i_s_valid,
    input  logic               i_s_ready,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic               i_window_end,
    input  logic [15:0]        i_fall_score,
    input  logic [15:0]        i_scream_score,
    input  logic               i_r_valid,
    input  logic               i_r_ready,
    input  logic [15:0]        i_fall_level,
    input  logic [15:0]        i_scream_level,
    input  logic               i_fall_suppressed,
    input  logic               i_alert,
    input  logic [15:0]        i_peak_delta,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked
);

    localparam logic [63:0] G_SCALED  = 64'd64290816; // 981 * 65536
    localparam logic [63:0] G_DIVISOR = 64'd15696;    // 981 * 16
    localparam logic [63:0] G_ROUND   = 64'd7848;

    fmg_pkg::t_cfg    cfg_copy;
    logic [15:0]      window_peak;
    fmg_pkg::t_result pending_decisions[$];

    function automatic logic [31:0] axis_power(input logic signed [15:0] a);
        logic [16:0] mag;
        mag = a[15] ? (17'h10000 - {1'b0, a}) : {1'b0, a};
        return 32'(mag) * 32'(mag);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] radicand);
        logic [63:0] rem, root, probe;
        rem   = radicand;
        root  = '0;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 0) begin
            if (rem >= root + probe) begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // |magnitude / 9.81 - 1 g| in Q4.12, rounded half up, saturating
    function automatic logic [15:0] g_deviation(input logic signed [15:0] x,
                                                 input logic signed [15:0] y,
                                                 input logic signed [15:0] z);
        logic [63:0] sum_sq, mag, scaled, offset, dev;
        sum_sq = 64'(axis_power(x)) + 64'(axis_power(y)) + 64'(axis_power(z));
        mag    = int_sqrt(sum_sq << 16);
        scaled = mag * 64'd100;
        offset = (scaled >= G_SCALED) ? scaled - G_SCALED : G_SCALED - scaled;
        dev    = (offset + G_ROUND) / G_DIVISOR;
        return (dev > 64'hFFFF) ? 16'hFFFF : dev[15:0];
    endfunction

    always @(posedge i_clk) begin : watch
        fmg_pkg::t_result want;
        logic [15:0]      dev;
        logic [15:0]      fall;
        logic             muted;
        if (!i_rst_n) begin
            cfg_copy     = '{fmg_pkg::MIN_MOTION_RST, fmg_pkg::FALL_TH_RST,
                             fmg_pkg::SCREAM_TH_RST};
            window_peak  = '0;
            pending_decisions.delete();
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (fmg_pkg::t_reg_idx'(paddr[3:2]))
                    fmg_pkg::REG_MIN_MOTION: cfg_copy.min_motion_delta = pwdata[15:0];
                    fmg_pkg::REG_FALL_TH:    cfg_copy.fall_threshold   = pwdata[15:0];
                    fmg_pkg::REG_SCREAM_TH:  cfg_copy.scream_threshold = pwdata[15:0];
                    default: ;
                endcase
            end

            if (i_r_valid && i_r_ready) begin
                if (pending_decisions.size() == 0) begin
                    $error("decision emitted with none outstanding");
                    o_fail_count++;
                end else begin
                    want = pending_decisions.pop_front();
                    o_checked++;
                    if (i_fall_level !== want.fall_level) begin
                        $error("fall_level: expected %0d, got %0d",
                               want.fall_level, i_fall_level);
                        o_fail_count++;
                    end
                    if (i_scream_level !== want.scream_level) begin
                        $error("scream_level: expected %0d, got %0d",
                               want.scream_level, i_scream_level);
                        o_fail_count++;
                    end
                    if (i_fall_suppressed !== want.fall_suppressed) begin
                        $error("fall_suppressed: expected %0d, got %0d",
                               want.fall_suppressed, i_fall_suppressed);
                        o_fail_count++;
                    end
                    if (i_alert !== want.alert) begin
                        $error("alert: expected %0d, got %0d", want.alert, i_alert);
                        o_fail_count++;
                    end
                    if (i_peak_delta !== want.peak_delta) begin
                        $error("peak_delta: expected %0d, got %0d",
                               want.peak_delta, i_peak_delta);
                        o_fail_count++;
                    end
                end
            end

            if (i_s_valid && i_s_ready) begin
                dev = g_deviation(i_accel_x, i_accel_y, i_accel_z);
                if (dev > window_peak)
                    window_peak = dev;
                if (i_window_end) begin
                    // only a score at or above threshold can be muted
                    muted = (i_fall_score >= cfg_copy.fall_threshold) &&
                            (window_peak < cfg_copy.min_motion_delta);
                    fall  = muted ? 16'd0 : i_fall_score;
                    want.fall_level      = fall;
                    want.scream_level    = i_scream_score;
                    want.fall_suppressed = muted;
                    want.alert           = (fall >= cfg_copy.fall_threshold) ||
                                           (i_scream_score >= cfg_copy.scream_threshold);
                    want.peak_delta      = window_peak;
                    pending_decisions.push_back(want);
                    window_peak = '0;
                end
            end
        end
        o_pending = pending_decisions.size();
    end

endmodule

FILE: tb/tb.sv
// Testbench top for the fall motion gate: stimulus, register writes and verdict.
`timescale 1ns / 100ps

module tb;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 100;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel, penable, pwrite, pready;
    logic [3:0]         paddr;
    logic [31:0]        pwdata, prdata;
    logic               i_valid, o_ready;
    logic signed [15:0] i_accel_x, i_accel_y, i_accel_z;
    logic               i_window_end;
    logic [15:0]        i_fall_score, i_scream_score;
    logic               o_valid, i_ready;
    logic [15:0]        o_fall_level, o_scream_level, o_peak_delta;
    logic               o_fall_suppressed, o_alert;

    int          fail_count, pending, checked;
    int          cycle_count;
    int          samples_sent, windows_sent, settings_used;
    logic [15:0] cur_motion, cur_fall_th, cur_scream_th;
    int          ready_hold;

    fall_motion_gate DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_accel_x(i_accel_x), .i_accel_y(i_accel_y), .i_accel_z(i_accel_z),
        .i_window_end(i_window_end), .i_fall_score(i_fall_score),
        .i_scream_score(i_scream_score),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_fall_level(o_fall_level), .o_scream_level(o_scream_level),
        .o_fall_suppressed(o_fall_suppressed), .o_alert(o_alert),
        .o_peak_delta(o_peak_delta)
    );

    fmg_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .i_s_valid(i_valid), .i_s_ready(o_ready),
        .i_accel_x(i_accel_x), .i_accel_y(i_accel_y), .i_accel_z(i_accel_z),
        .i_window_end(i_window_end), .i_fall_score(i_fall_score),
        .i_scream_score(i_scream_score),
        .i_r_valid(o_valid), .i_r_ready(i_ready),
        .i_fall_level(o_fall_level), .i_scream_level(o_scream_level),
        .i_fall_suppressed(o_fall_suppressed), .i_alert(o_alert),
        .i_peak_delta(o_peak_delta),
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side back-pressure: calm stretches, short and occasional long stalls
    always @(negedge i_clk) begin : ready_gen
        int r;
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                i_ready <= 1'b1; ready_hold <= $urandom_range(100, 300);
            end else if (r < 60) begin
                i_ready <= 1'b1; ready_hold <= $urandom_range(0, 5);
            end else if (r < 90) begin
                i_ready <= 1'b0; ready_hold <= $urandom_range(0, 2);
            end else if (r < 97) begin
                i_ready <= 1'b0; ready_hold <= $urandom_range(3, 11);
            end else begin
                i_ready <= 1'b0; ready_hold <= $urandom_range(19, 39);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d decisions outstanding", cycle_count, pending);
        $display("status: fail");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [15:0] pick_axis();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 16'($signed($urandom_range(0, 8000)) - 4000);
        if (r < 85) return 16'($urandom);
        case ($urandom_range(0, 3))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic logic [15:0] pick_score(input logic [15:0] th);
        int r, v;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            v = int'(th) + int'($urandom_range(0, 6)) - 3;
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
            return 16'(v);
        end
        if (r < 45) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        return 16'($urandom);
    endfunction

    // drives one sample and returns at the edge where it is taken
    task automatic send_sample(input logic [15:0] ax, input logic [15:0] ay,
                               input logic [15:0] az, input logic we,
                               input logic [15:0] fs, input logic [15:0] ss,
                               input logic no_gap);
        int gap;
        gap = no_gap ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_accel_x      <= ax;
        i_accel_y      <= ay;
        i_accel_z      <= az;
        i_window_end   <= we;
        i_fall_score   <= fs;
        i_scream_score <= ss;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        samples_sent++;
        if (we) windows_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // drain, then allow for samples still in flight that cause no decision
    task automatic settle();
        wait_drained();
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_reg(input fmg_pkg::t_reg_idx idx, input logic [15:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_config(input logic [15:0] motion, input logic [15:0] fall_th,
                                input logic [15:0] scream_th);
        settle();
        write_reg(fmg_pkg::REG_MIN_MOTION, motion);
        write_reg(fmg_pkg::REG_FALL_TH, fall_th);
        write_reg(fmg_pkg::REG_SCREAM_TH, scream_th);
        cur_motion    = motion;
        cur_fall_th   = fall_th;
        cur_scream_th = scream_th;
        settings_used++;
    endtask

    task automatic run_windows(input int n_samples);
        int sent, len, k, r;
        logic burst, last;
        sent = 0;
        while (sent < n_samples) begin
            r   = $urandom_range(0, 99);
            len = (r < 70) ? $urandom_range(2, 6) : (r < 85) ? $urandom_range(7, 24) : 1;
            burst = ($urandom_range(0, 99) < 15);
            for (k = 0; k < len; k++) begin
                last = (k == len - 1);
                send_sample(pick_axis(), pick_axis(), pick_axis(), last,
                            last ? pick_score(cur_fall_th) : 16'($urandom),
                            last ? pick_score(cur_scream_th) : 16'($urandom), burst);
            end
            sent += len;
            if ($urandom_range(0, 99) < 3)
                wait_drained();
        end
    endtask

    initial begin : stimulus
        int p, style;
        i_clk = 1'b0;       i_rst_n = 1'b0;
        psel = 1'b0;        penable = 1'b0;   pwrite = 1'b0;
        paddr = '0;         pwdata = '0;
        i_valid = 1'b0;     i_ready = 1'b0;   ready_hold = 0;
        i_accel_x = '0;     i_accel_y = '0;   i_accel_z = '0;
        i_window_end = 1'b0;
        i_fall_score = '0;  i_scream_score = '0;
        samples_sent = 0;   windows_sent = 0; settings_used = 0;
        cur_motion = fmg_pkg::MIN_MOTION_RST;
        cur_fall_th = fmg_pkg::FALL_TH_RST;
        cur_scream_th = fmg_pkg::SCREAM_TH_RST;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: resting sample, saturation, thresholds met exactly
        send_sample(16'h0000, 16'h0000, 16'h0000, 1'b0, 16'hFFFF, 16'hFFFF, 1'b0);
        send_sample(16'h8000, 16'h8000, 16'h8000, 1'b1, 16'hFFFF, 16'h0000, 1'b0);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 16'd52429, 16'd52428, 1'b0);
        // about 1 g at rest: a high fall score is muted
        send_sample(16'h0000, 16'h0000, 16'd2511, 1'b1, 16'hFFFF, 16'h0000, 1'b0);
        // small motion with score just under threshold passes unchanged
        send_sample(16'd2511, 16'h0000, 16'h0000, 1'b1, 16'd52428, 16'h0000, 1'b0);
        send_sample(16'h0000, -16'sd2511, 16'h0000, 1'b0, 16'h1234, 16'h4321, 1'b0);
        send_sample(16'h0000, 16'h0000, -16'sd7000, 1'b1, 16'd52429, 16'd52429, 1'b0);
        send_sample(16'h8000, 16'h0000, 16'h0000, 1'b1, 16'h0000, 16'hFFFF, 1'b0);
        send_sample(16'd100, 16'd200, 16'd300, 1'b0, 16'hFFFF, 16'h0000, 1'b1);
        send_sample(16'd5000, 16'd5000, 16'd5000, 1'b0, 16'h0000, 16'hFFFF, 1'b1);
        send_sample(16'h0000, 16'h0000, 16'h0000, 1'b1, 16'd60000, 16'd1000, 1'b1);

        // zero thresholds: every decision alerts, nothing is muted
        apply_config(16'h0000, 16'h0000, 16'h0000);
        send_sample(16'h0000, 16'h0000, 16'd2511, 1'b1, 16'h0000, 16'h0000, 1'b0);
        send_sample(16'd1, -16'sd1, 16'd1, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0);
        send_sample(16'h7FFF, 16'h8000, 16'h0001, 1'b1, 16'h0001, 16'h0000, 1'b0);

        // top thresholds: a top fall score is muted unless the peak saturates
        apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(16'h8000, 16'h8000, 16'h8000, 1'b1, 16'hFFFF, 16'hFFFE, 1'b0);
        send_sample(16'h0000, 16'h0000, 16'd2511, 1'b1, 16'hFFFF, 16'h0000, 1'b0);
        send_sample(16'h0000, 16'h0000, 16'd2511, 1'b1, 16'hFFFE, 16'hFFFF, 1'b0);

        apply_config(fmg_pkg::MIN_MOTION_RST, fmg_pkg::FALL_TH_RST, fmg_pkg::SCREAM_TH_RST);
        run_windows(250);
        for (p = 0; p < 7; p++) begin
            style = $urandom_range(0, 2);
            if (style == 0)
                apply_config(16'($urandom), 16'($urandom), 16'($urandom));
            else if (style == 1)
                apply_config(16'($urandom_range(2048, 20000)),
                             16'($urandom_range(40000, 60000)),
                             16'($urandom_range(40000, 60000)));
            else
                apply_config(16'($urandom_range(20000, 65535)),
                             16'($urandom_range(0, 4000)),
                             16'($urandom_range(60000, 65535)));
            run_windows(250);
        end

        settle();
        $display("covered %0d samples in %0d windows over %0d register settings",
                 samples_sent, windows_sent, settings_used);
        $display("%0d decisions compared, %0d mismatches", checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
